FILE: rtl/best_worst_fit_block_allocator_top_macros.svh
// Assertion helpers for the allocator RTL.
// Both use the clock and reset port names of the module that includes them.
`ifndef BEST_WORST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BEST_WORST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define BWFBA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BWFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bwfba_pkg.sv
`timescale 1ns / 1ps

package bwfba_pkg;

   localparam int NUM_BLOCKS = 8;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = $clog2(NUM_BLOCKS);

   // field widths fixed by the item formats
   localparam int SEL_BITS    = 3;
   localparam int AMOUNT_BITS = 16;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_ALLOC = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_LOADED   = 2'd0,
      STAT_ASSIGNED = 2'd1,
      STAT_NO_FIT   = 2'd2
   } status_type;

   typedef enum logic {
      CSR_FIT_POLICY     = 1'b0,
      CSR_PARTITION_MODE = 1'b1
   } csr_index_type;

   typedef enum logic {
      FIT_BEST  = 1'b0,
      FIT_WORST = 1'b1
   } fit_policy_type;

   typedef enum logic {
      PART_VARIABLE = 1'b0,
      PART_FIXED    = 1'b1
   } partition_mode_type;

   typedef struct packed {
      op_type                 op;
      logic [SEL_BITS-1:0]    block_select;
      logic [AMOUNT_BITS-1:0] amount;
   } req_payload_type;

   typedef struct packed {
      status_type             status;
      logic [SEL_BITS-1:0]    block_index;
      logic [AMOUNT_BITS-1:0] leftover;
   } rsp_payload_type;

endpackage

FILE: rtl/best_worst_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// Best/worst fit block allocator. Holds a free-space counter per block (all zero
// after reset). A load transfer writes one block's counter and returns status
// "loaded". An allocate transfer scans every block with a single shared
// subtract/compare unit, one block per cycle, and picks the fitting block with
// the smallest (best fit) or largest (worst fit) leftover, lowest index on a
// tie. It then shrinks that block by the request (variable mode) or zeroes it
// (fixed mode) and returns its index and leftover, or "no fit". A load goes
// from idle straight to the done state; an allocate passes through the scan
// state first. The done state loads the output register once it is free.
// req_ready is high only while the sequencer is idle, so one item is in flight
// at a time; the result sits in an output register and the next request can be
// taken while it waits. Write the CSRs only while idle with no result pending.
`include "best_worst_fit_block_allocator_top_macros.svh"

module best_worst_fit_block_allocator_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bwfba_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bwfba_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  bwfba_pkg::csr_index_type  csr_index,
   input  logic                      csr_wdata
);
   import bwfba_pkg::*;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_BLOCKS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // config
   fit_policy_type     fit_policy_ff;
   partition_mode_type partition_mode_ff;

   // free-space table
   logic [SIZE_BITS-1:0] block_space_ff [NUM_BLOCKS];

   // captured request
   op_type               op_ff;
   logic [SEL_BITS-1:0]  sel_ff;
   logic [SIZE_BITS-1:0] amount_ff;

   // scan state
   logic [IDX_BITS-1:0]  scan_idx_ff;
   logic                 found_ff;
   logic [IDX_BITS-1:0]  pick_ff;
   logic [SIZE_BITS-1:0] best_ff;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic                 req_xfer;
   logic                 rsp_slot_free;
   logic [SIZE_BITS-1:0] room;
   logic [SIZE_BITS-1:0] rest;
   logic                 fits;
   logic                 take;
   logic                 load_in_range;
   logic [IDX_BITS-1:0]  load_idx;
   logic [SIZE_BITS-1:0] new_space;
   rsp_payload_type      rsp_next;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_xfer      = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_data_ff;
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   // shared scan unit: one block per cycle
   assign room = block_space_ff[scan_idx_ff];
   assign fits = (amount_ff <= room);
   assign rest = room - amount_ff;
   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (fit_policy_ff == FIT_BEST) begin
            take = (rest < best_ff);
         end else begin
            take = (rest > best_ff);
         end
      end
   end

   // load target; a select past the table is dropped
   assign load_in_range = (32'(sel_ff) < NUM_BLOCKS);
   assign load_idx      = IDX_BITS'(sel_ff);

   assign new_space = (partition_mode_ff == PART_VARIABLE) ? best_ff : '0;

   always_comb begin
      rsp_next = '0;
      if (op_ff == OP_LOAD) begin
         rsp_next.status = STAT_LOADED;
      end else if (found_ff) begin
         rsp_next.status      = STAT_ASSIGNED;
         rsp_next.block_index = SEL_BITS'(pick_ff);
         rsp_next.leftover    = AMOUNT_BITS'(new_space);
      end else begin
         rsp_next.status = STAT_NO_FIT;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_payload.op == OP_ALLOC) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff     <= FIT_BEST;
         partition_mode_ff <= PART_VARIABLE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIT_POLICY:     fit_policy_ff     <= fit_policy_type'(csr_wdata);
            CSR_PARTITION_MODE: partition_mode_ff <= partition_mode_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff     <= req_payload.op;
         sel_ff    <= req_payload.block_select;
         amount_ff <= SIZE_BITS'(req_payload.amount);
      end
   end

   // scan bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else if (req_xfer) begin
         scan_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN) && take) begin
         pick_ff <= scan_idx_ff;
         best_ff <= rest;
      end
   end

   // table update at result time
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            block_space_ff[i] <= '0;
         end
      end else if ((state_ff == ST_DONE) && rsp_slot_free) begin
         if (op_ff == OP_LOAD) begin
            if (load_in_range) begin
               block_space_ff[load_idx] <= amount_ff;
            end
         end else if (found_ff) begin
            block_space_ff[pick_ff] <= new_space;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_data_ff <= '0;
      end else if ((state_ff == ST_DONE) && rsp_slot_free) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // checks
   `BWFBA_ASSERT_NEXT(a_busy_after_req, req_xfer, !req_ready, "request taken while busy")
   `BWFBA_ASSERT_NEXT(a_scan_holds_rsp, state_ff == ST_SCAN, $stable(rsp_data_ff), "result changed during scan")
   `BWFBA_ASSERT_NOW(a_fixed_leftover, rsp_valid_ff && (partition_mode_ff == PART_FIXED) && (rsp_data_ff.status == STAT_ASSIGNED), rsp_data_ff.leftover == '0, "fixed mode leftover not zero")
   `BWFBA_ASSERT_NOW(a_unassigned_zero, rsp_valid_ff && (rsp_data_ff.status != STAT_ASSIGNED), (rsp_data_ff.block_index == '0) && (rsp_data_ff.leftover == '0), "unassigned result has data")

endmodule
